>>> rtl/nearest_prototype_classifier_defines.svh
// Assertion macros for the nearest prototype classifier.
// Included by the top level; no other dependencies.
`ifndef NEAREST_PROTOTYPE_CLASSIFIER_DEFINES_SVH
`define NEAREST_PROTOTYPE_CLASSIFIER_DEFINES_SVH
`ifndef SYNTHESIS
`define NPC_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NPC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define NPC_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define NPC_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/npc_pkg.sv
// Shared types and constants of the nearest prototype classifier.
// No dependencies.
`timescale 1ns / 1ps
package npc_pkg;
  localparam int MAX_PROTOTYPES_DEF = 64;
  localparam int NUM_FEATURES_DEF   = 20;
  localparam int FEATURE_WIDTH_DEF  = 16;

  localparam logic [2:0] ST_CLASSIFIED = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_STORED     = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_LENGTH     = 3'd4;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] feature;
    logic [7:0]         label_id;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  best_label;
    logic [15:0] confidence;
  } out_item_t;

  // Start request from the controller to the divider.
  typedef struct packed {
    logic start;
  } div_req_t;
endpackage

>>> rtl/npc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module npc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/npc_isqrt.sv
// Bit-serial integer square root, bringing down two radicand bits per cycle.
// Depends on nothing but its ports.
`timescale 1ns / 1ps
module npc_isqrt #(
  parameter int W = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   radicand,
  output logic           done,
  output logic [W/2-1:0] root
);
  localparam int STEPS = W / 2;
  localparam int CW = $clog2(STEPS + 1);

  logic [W-1:0]   rem_r;
  logic [W-1:0]   src_r;
  logic [W/2-1:0] root_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [W/2+1:0] trial;
  logic [W/2+1:0] rem_top;

  // Classic digit-by-digit method: bring down two bits, try 4*root+1.
  always_comb begin
    rem_top = {rem_r[W/2-1:0], src_r[W-1 -: 2]};
    trial   = {root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= '0;
        src_r  <= radicand;
        root_r <= '0;
        cnt_r  <= CW'(STEPS);
      end else if (busy_r) begin
        src_r <= src_r << 2;
        if (rem_top >= trial) begin
          rem_r  <= W'(rem_top - trial);
          root_r <= {root_r[W/2-2:0], 1'b1};
        end else begin
          rem_r  <= W'(rem_top);
          root_r <= {root_r[W/2-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

>>> rtl/npc_divider.sv
// Restoring divider for the confidence ratio, one quotient bit per cycle.
// Depends on nothing but its ports.
`timescale 1ns / 1ps
module npc_divider #(
  parameter int W = 49
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  dsr_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    shifted;

  assign shifted = {rem_r, quo_r[W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        quo_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        if (shifted >= {1'b0, dsr_r}) begin
          rem_r <= W'(shifted - {1'b0, dsr_r});
          quo_r <= {quo_r[W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

>>> rtl/nearest_prototype_classifier.sv
// Nearest prototype classifier: feature vectors arrive one feature per transfer. Vectors of
// kind 0 are stored with their label; a query walks the prototype table in memory,
// accumulating squared differences one feature at a time (read issue, difference, then square
// and add), takes an integer square root per prototype and finishes with a divider for
// the confidence. A stored vector is copied from the query buffer into the feature memory.
// No clearing pass.
// Depends on npc_pkg, npc_ram, npc_isqrt, npc_divider and the assertion macro header.
`timescale 1ns / 1ps
`include "nearest_prototype_classifier_defines.svh"
module nearest_prototype_classifier #(
  parameter int MAX_PROTOTYPES = npc_pkg::MAX_PROTOTYPES_DEF,
  parameter int NUM_FEATURES   = npc_pkg::NUM_FEATURES_DEF,
  parameter int FEATURE_WIDTH  = npc_pkg::FEATURE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  npc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output npc_pkg::out_item_t out_data
);
  import npc_pkg::*;

  localparam int PW  = $clog2(MAX_PROTOTYPES + 1);
  localparam int PAW = (MAX_PROTOTYPES > 1) ? $clog2(MAX_PROTOTYPES) : 1;
  localparam int FPW = $clog2(NUM_FEATURES + 2);
  localparam int FAW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int MD  = MAX_PROTOTYPES * NUM_FEATURES;
  localparam int MAW = (MD > 1) ? $clog2(MD) : 1;
  localparam int SW  = 64;
  localparam int RW  = SW / 2;
  localparam int DW  = RW + 17;

  typedef enum logic [3:0] {
    S_IDLE, S_COPY, S_QRD, S_ACC, S_SQRT, S_CMP, S_DIV, S_DIVW, S_OUT
  } state_t;

  state_t           state_r;
  logic [PW-1:0]    count_r;
  logic [FPW-1:0]   pos_r;
  logic [FAW-1:0]   fi_r;
  logic [PW-1:0]    pi_r;
  logic [MAW-1:0]   base_r;
  logic             rd_vld_r;
  logic [FAW-1:0]   rd_fi_r;
  logic [SW-1:0]    sum_r;
  logic [SW-1:0]    sum_nxt;
  logic             sq_go_r;
  logic [RW-1:0]    best_r;
  logic [RW-1:0]    second_r;
  logic             have_best_r;
  logic             have_second_r;
  logic [7:0]       label_r;
  logic [7:0]       in_label_r;
  logic [7:0]       best_label_r;
  out_item_t        out_r;
  logic             out_valid_r;
  logic signed [FEATURE_WIDTH:0]     diff_r;
  logic signed [2*FEATURE_WIDTH+1:0] sq;
  logic signed [FEATURE_WIDTH-1:0]   feat_in;

  // Memory ports.
  logic                       qb_we;
  logic [FAW-1:0]             qb_waddr;
  logic [FAW-1:0]             qb_raddr;
  logic [FEATURE_WIDTH-1:0]   qb_rdata;
  logic                       pf_we;
  logic [MAW-1:0]             pf_waddr;
  logic [MAW-1:0]             pf_raddr;
  logic [FEATURE_WIDTH-1:0]   pf_rdata;
  logic                       pl_we;
  logic [7:0]                 pl_rdata;

  logic           sq_start;
  logic           sq_done;
  logic [RW-1:0]  sq_root;
  div_req_t       div_req;
  logic           div_done;
  logic [DW-1:0]  div_q;
  logic [DW-1:0]  div_num;
  logic [DW-1:0]  div_den;

  logic accept;
  assign feat_in  = in_data.feature[FEATURE_WIDTH-1:0];
  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign accept   = in_valid && !in_stall;

  assign qb_we    = accept && (pos_r < FPW'(NUM_FEATURES));
  assign qb_waddr = pos_r[FAW-1:0];
  assign qb_raddr = fi_r;
  assign pf_we    = (state_r == S_COPY) && rd_vld_r;
  assign pf_waddr = MAW'(base_r + MAW'(rd_fi_r));
  assign pf_raddr = MAW'(base_r + MAW'(fi_r));
  assign pl_we    = (state_r == S_COPY) && rd_vld_r && (rd_fi_r == FAW'(NUM_FEATURES - 1));

  npc_ram #(.WIDTH(FEATURE_WIDTH), .DEPTH(NUM_FEATURES)) u_query (
    .clk(clk), .we(qb_we), .waddr(qb_waddr), .wdata(feat_in),
    .raddr(qb_raddr), .rdata(qb_rdata)
  );
  npc_ram #(.WIDTH(FEATURE_WIDTH), .DEPTH(MD)) u_feat (
    .clk(clk), .we(pf_we), .waddr(pf_waddr), .wdata(qb_rdata),
    .raddr(pf_raddr), .rdata(pf_rdata)
  );
  npc_ram #(.WIDTH(8), .DEPTH(MAX_PROTOTYPES)) u_label (
    .clk(clk), .we(pl_we), .waddr(count_r[PAW-1:0]), .wdata(in_label_r),
    .raddr(pi_r[PAW-1:0]), .rdata(pl_rdata)
  );

  assign sq      = diff_r * diff_r;
  assign sum_nxt = sum_r + SW'(sq);

  // The root unit takes the completed sum as the last square is added.
  npc_isqrt #(.W(SW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sum_nxt),
    .done(sq_done), .root(sq_root)
  );

  assign div_num = {1'b0, second_r - best_r, 16'd0};
  assign div_den = DW'({1'b0, second_r} + {1'b0, best_r});

  npc_divider #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_req.start), .dividend(div_num),
    .divisor(div_den), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    sq_start      = (state_r == S_ACC) && sq_go_r && !rd_vld_r
                  && (rd_fi_r == FAW'(NUM_FEATURES - 1));
    div_req.start = (state_r == S_DIV);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      sq_go_r     <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_data.last) begin
              pos_r <= '0;
              in_label_r <= in_data.label_id;
              if (pos_r != FPW'(NUM_FEATURES - 1)) begin
                out_r       <= {ST_LENGTH, 8'd0, 16'd0};
                out_valid_r <= 1'b1;
              end else if (!in_data.kind) begin
                if (count_r >= PW'(MAX_PROTOTYPES)) begin
                  out_r       <= {ST_FULL, 8'd0, 16'd0};
                  out_valid_r <= 1'b1;
                end else begin
                  fi_r     <= '0;
                  base_r   <= MAW'(count_r * NUM_FEATURES);
                  rd_vld_r <= 1'b0;
                  state_r  <= S_COPY;
                end
              end else if (count_r == '0) begin
                out_r       <= {ST_EMPTY, 8'd0, 16'd0};
                out_valid_r <= 1'b1;
              end else begin
                pi_r          <= '0;
                base_r        <= '0;
                fi_r          <= '0;
                sum_r         <= '0;
                rd_vld_r      <= 1'b0;
                have_best_r   <= 1'b0;
                have_second_r <= 1'b0;
                state_r       <= S_QRD;
              end
            end else if (pos_r <= FPW'(NUM_FEATURES)) begin
              pos_r <= pos_r + 1'b1;
            end
          end
        end
        S_COPY: begin
          // Query buffer read feeds the feature memory write in the following cycle.
          rd_fi_r <= fi_r;
          if (fi_r != FAW'(NUM_FEATURES - 1)) begin
            fi_r <= fi_r + 1'b1;
          end
          if (rd_vld_r && rd_fi_r == FAW'(NUM_FEATURES - 1)) begin
            rd_vld_r    <= 1'b0;
            count_r     <= count_r + 1'b1;
            out_r       <= {ST_STORED, 8'd0, 16'd0};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            rd_vld_r <= 1'b1;
          end
        end
        S_QRD: begin
          // Issue reads of feature fi for query and prototype.
          rd_fi_r  <= fi_r;
          rd_vld_r <= 1'b1;
          state_r  <= S_ACC;
        end
        S_ACC: begin
          if (rd_vld_r) begin
            diff_r   <= $signed({qb_rdata[FEATURE_WIDTH-1], qb_rdata})
                      - $signed({pf_rdata[FEATURE_WIDTH-1], pf_rdata});
            rd_vld_r <= 1'b0;
            sq_go_r  <= 1'b1;
          end else if (sq_go_r) begin
            sum_r   <= sum_nxt;
            sq_go_r <= 1'b0;
            if (rd_fi_r == FAW'(NUM_FEATURES - 1)) begin
              state_r <= S_SQRT;
              fi_r    <= '0;
            end else begin
              fi_r    <= fi_r + 1'b1;
              state_r <= S_QRD;
            end
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            label_r <= pl_rdata;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (!have_best_r || sq_root < best_r) begin
            if (have_best_r) begin
              second_r      <= best_r;
              have_second_r <= 1'b1;
            end
            best_r       <= sq_root;
            best_label_r <= label_r;
            have_best_r  <= 1'b1;
          end else if (!have_second_r || sq_root < second_r) begin
            second_r      <= sq_root;
            have_second_r <= 1'b1;
          end
          sum_r <= '0;
          if (pi_r + 1'b1 == count_r) begin
            state_r <= S_DIV;
          end else begin
            pi_r    <= pi_r + 1'b1;
            base_r  <= MAW'(base_r + MAW'(NUM_FEATURES));
            state_r <= S_QRD;
          end
        end
        S_DIV: begin
          state_r <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          out_r.status     <= ST_CLASSIFIED;
          out_r.best_label <= best_label_r;
          if (!have_second_r) begin
            out_r.confidence <= 16'hFFFF;
          end else if (second_r == '0) begin
            out_r.confidence <= 16'h8000;
          end else if (div_q > DW'(16'hFFFF)) begin
            out_r.confidence <= 16'hFFFF;
          end else begin
            out_r.confidence <= div_q[15:0];
          end
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `NPC_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, (state_r != S_IDLE) |-> !accept, "busy accept")
  `NPC_ASSERT_NEVER(a_count_range, clk, rst_n, count_r > PW'(MAX_PROTOTYPES), "count overflow")
  `NPC_ASSERT_IMPL(a_out_hold, clk, rst_n, (out_valid_r && out_stall) |=> out_valid_r, "dropped")
endmodule

>>> bench/nearest_prototype_classifier_test.sv
// Self-checking bench for the nearest prototype classifier: random and directed
// feature transfers, results compared against a behavioural model in a scoreboard class.
// Depends on npc_pkg and the nearest_prototype_classifier RTL.
`timescale 1ns / 1ps
module nearest_prototype_classifier_test;
  import npc_pkg::*;

  localparam int NPROTO = MAX_PROTOTYPES_DEF;
  localparam int NFEAT  = NUM_FEATURES_DEF;

  class classifier_scoreboard;
    logic signed [15:0] table_feat [NPROTO][NFEAT];
    logic [7:0]         table_label [NPROTO];
    int                 table_count;
    logic signed [15:0] assembly [NFEAT];
    int                 position;
    out_item_t          pending [$];
    int                 errors;

    function new();
      table_count = 0;
      position = 0;
      errors = 0;
    endfunction

    function automatic longint unsigned int_root(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    function automatic longint unsigned distance(int p);
      longint unsigned sum;
      longint d;
      sum = 0;
      for (int i = 0; i < NFEAT; i++) begin
        d = longint'(assembly[i]) - longint'(table_feat[p][i]);
        if (d < 0) d = -d;
        sum += longint'(d) * longint'(d);
      end
      return int_root(sum);
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      longint unsigned best, second, d, q;
      bit have_best, have_second;
      if (position < NFEAT) assembly[position] = it.feature;
      if (position <= NFEAT) position++;
      if (!it.last) return;
      r = '0;
      if (position != NFEAT) begin
        r.status = ST_LENGTH;
      end else if (it.kind == 1'b0) begin
        if (table_count >= NPROTO) begin
          r.status = ST_FULL;
        end else begin
          for (int i = 0; i < NFEAT; i++) table_feat[table_count][i] = assembly[i];
          table_label[table_count] = it.label_id;
          table_count++;
          r.status = ST_STORED;
        end
      end else if (table_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        have_best = 0;
        have_second = 0;
        best = 0;
        second = 0;
        for (int p = 0; p < table_count; p++) begin
          d = distance(p);
          if (!have_best || d < best) begin
            if (have_best) begin
              second = best;
              have_second = 1;
            end
            best = d;
            r.best_label = table_label[p];
            have_best = 1;
          end else if (!have_second || d < second) begin
            second = d;
            have_second = 1;
          end
        end
        if (!have_second) r.confidence = 16'hFFFF;
        else if (second == 0) r.confidence = 16'h8000;
        else begin
          q = ((second - best) << 16) / (second + best);
          r.confidence = (q > 65535) ? 16'hFFFF : q[15:0];
        end
        r.status = ST_CLASSIFIED;
      end
      position = 0;
      pending = {pending, r};
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result status=%0d", got.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status);
        errors++;
      end
      if (got.best_label !== e.best_label) begin
        $error("best_label expected %0d actual %0d", e.best_label, got.best_label);
        errors++;
      end
      if (got.confidence !== e.confidence) begin
        $error("confidence expected %0d actual %0d", e.confidence, got.confidence);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_data;

  classifier_scoreboard board = new();
  int long_hold = 0;
  bit all_sent = 0;

  nearest_prototype_classifier DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // Mostly small features so prototypes near a query are common, with full-range extremes.
  function automatic logic signed [15:0] pick_feature(int mode);
    case (mode)
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: begin
        if ($urandom_range(0, 3) == 0) return 16'($urandom());
        return $signed(16'($urandom_range(0, 255))) - 16'sd128;
      end
    endcase
  endfunction

  // Holds valid across consecutive transfers; an idle gap lowers it for whole cycles.
  task automatic send_item(in_item_t it, bit allow_gap);
    int g;
    g = allow_gap ? gap_length() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(it);
  endtask

  task automatic send_vector(bit kind, int count, int mode, logic [7:0] label, bit gaps);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      it.kind = (i == count - 1) ? kind : 1'($urandom());
      it.feature = pick_feature(mode);
      it.label_id = (i == count - 1) ? label : 8'($urandom());
      it.last = (i == count - 1);
      send_item(it, gaps);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: empty table, length errors, extremes, a tie and one-prototype confidence.
    send_vector(1, NFEAT, 2, 0, 0);
    send_vector(0, NFEAT - 1, 2, 8'h11, 0);
    send_vector(0, NFEAT + 2, 2, 8'h12, 0);
    send_vector(0, NFEAT, 0, 8'hFF, 0);
    send_vector(1, NFEAT, 1, 0, 0);
    send_vector(0, NFEAT, 0, 8'h00, 0);
    send_vector(1, NFEAT, 0, 0, 0);
    send_vector(0, NFEAT, 1, 8'h5A, 0);
    send_vector(1, NFEAT, 2, 0, 0);
    send_vector(1, 1, 2, 0, 0);
    wait_drained();
    // Random: vectors of well-formed length mostly, the odd broken one.
    for (int v = 0; v < 28; v++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, NFEAT + 3) : NFEAT;
      send_vector(($urandom_range(0, 2) == 0), len, 3, 8'($urandom()), 1);
      if (v == 14) begin
        wait_drained();
        long_hold = 400;
      end
    end
    wait_drained();
    for (int v = 0; v < 4; v++) send_vector(1, NFEAT, 3, 0, 1);
    send_vector(1, NFEAT, 0, 0, 1);
    in_valid <= 1'b0;
    all_sent = 1;
  end

  // Receiver: random stalls, plus one long hold-off requested by the sender.
  initial begin
    int g;
    forever begin
      if (long_hold > 0) begin
        out_stall <= 1'b1;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
      end
      g = gap_length();
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  initial begin
    wait (all_sent);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
